// ===== design/kpd_pkg.sv =====
// Shared types and constants for the key short/long press detector.
package kpd_pkg;

   // Width of the sampled key levels and of each result bit vector.
   localparam int KEY_W = 4;

   // Width of the configuration registers.
   localparam int CSR_DATA_W = 8;

   // Width of the configuration register index.
   localparam int CSR_INDEX_W = 1;

   // Reset values of the configuration registers.
   localparam logic [CSR_DATA_W-1:0] LONG_THRESHOLD_RESET  = 8'd78;
   localparam logic [CSR_DATA_W-1:0] REPEAT_INTERVAL_RESET = 8'd15;

   // Saturation limit of the per-key hold counter.
   localparam logic [CSR_DATA_W-1:0] HOLD_COUNT_MAX = 8'hFF;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LONG_THRESHOLD  = 1'b0,
      CSR_REPEAT_INTERVAL = 1'b1
   } csr_index_type;

   // Per-key press phases.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FIRST = 2'd1,
      PH_HELD  = 2'd2,
      PH_LONG  = 2'd3
   } phase_type;

   // Pulses one lane reports for the current tick.
   typedef struct packed {
      logic short_hit;
      logic long_hit;
   } lane_result_type;

   // One result item.
   typedef struct packed {
      logic [KEY_W-1:0] short_press;
      logic [KEY_W-1:0] long_press;
   } result_type;

endpackage

// ===== design/kpd_req_if.sv =====
// Input channel carrying one tick of sampled key levels.
interface kpd_req_if;

   logic                     valid;
   logic                     ready;
   logic [kpd_pkg::KEY_W-1:0] key_levels;

   modport source (output valid, output key_levels, input ready);
   modport sink   (input valid, input key_levels, output ready);

endinterface

// ===== design/kpd_rsp_if.sv =====
// Result channel carrying the short and long press pulses of one tick.
interface kpd_rsp_if;

   logic                     valid;
   logic                     ready;
   logic [kpd_pkg::KEY_W-1:0] short_press;
   logic [kpd_pkg::KEY_W-1:0] long_press;

   modport source (output valid, output short_press, output long_press, input ready);
   modport sink   (input valid, input short_press, input long_press, output ready);

endinterface

// ===== design/kpd_lane.sv =====
// Per-key press phase machine with its hold counter.
module kpd_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                pressed,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]      long_threshold,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]      repeat_interval,
   output kpd_pkg::lane_result_type            result
);

   kpd_pkg::phase_type                 phase_ff, phase_in;
   logic [kpd_pkg::CSR_DATA_W-1:0]     count_ff, count_in;
   logic [kpd_pkg::CSR_DATA_W-1:0]     count_inc;

   // Saturating increment of the hold count.
   assign count_inc = (count_ff == kpd_pkg::HOLD_COUNT_MAX) ? count_ff
                                                          : count_ff + 8'd1;

   // Next phase and next hold count.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (advance) begin
         unique case (phase_ff)
            kpd_pkg::PH_IDLE: begin
               if (pressed) phase_in = kpd_pkg::PH_FIRST;
            end
            kpd_pkg::PH_FIRST: begin
               phase_in = pressed ? kpd_pkg::PH_HELD : kpd_pkg::PH_IDLE;
            end
            kpd_pkg::PH_HELD: begin
               count_in = count_inc;
               if (count_inc < long_threshold && !pressed) begin
                  phase_in = kpd_pkg::PH_IDLE;
                  count_in = '0;
               end else if (count_inc >= long_threshold) begin
                  phase_in = kpd_pkg::PH_LONG;
               end
            end
            kpd_pkg::PH_LONG: begin
               if (pressed) begin
                  count_in = (count_inc >= repeat_interval) ? '0 : count_inc;
               end else begin
                  phase_in = kpd_pkg::PH_IDLE;
                  count_in = '0;
               end
            end
            default: begin
               phase_in = kpd_pkg::PH_IDLE;
               count_in = '0;
            end
         endcase
      end
   end

   // Pulses for this tick.
   always_comb begin
      result.short_hit = 1'b0;
      result.long_hit  = 1'b0;
      if (advance) begin
         unique case (phase_ff)
            kpd_pkg::PH_HELD: begin
               result.short_hit = (count_inc < long_threshold) && !pressed;
            end
            kpd_pkg::PH_LONG: begin
               result.long_hit = pressed && (count_inc >= repeat_interval);
            end
            default: begin
               result.short_hit = 1'b0;
               result.long_hit  = 1'b0;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kpd_pkg::PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   // A short press always ends the press and clears the count.
   a_short_ends_press: assert property (@(posedge clock) disable iff (reset)
      result.short_hit |=> (phase_ff == kpd_pkg::PH_IDLE) && (count_ff == '0))
      else $error("short press did not return the key to idle");

   // A long pulse restarts the repeat count while the key stays long-held.
   a_long_restarts: assert property (@(posedge clock) disable iff (reset)
      result.long_hit |=> (phase_ff == kpd_pkg::PH_LONG) && (count_ff == '0))
      else $error("long pulse did not restart the repeat count");

   // Idle and first-sample phases never carry a count.
   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == kpd_pkg::PH_IDLE || phase_ff == kpd_pkg::PH_FIRST) |-> (count_ff == '0))
      else $error("hold count set outside a held phase");
`endif

endmodule

// ===== design/kpd_merge.sv =====
// Merges the lane pulses into a result item and buffers it for the result channel.
module kpd_merge #(
   parameter int NUM_KEYS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kpd_pkg::lane_result_type  lane_result [NUM_KEYS],
   output logic                      can_push,
   kpd_rsp_if.source                 rsp_chan
);

   localparam int SHOWN_KEYS = (NUM_KEYS < kpd_pkg::KEY_W) ? NUM_KEYS : kpd_pkg::KEY_W;

   kpd_pkg::result_type  merged;
   kpd_pkg::result_type  out_data_ff, out_data_in;
   kpd_pkg::result_type  skid_data_ff, skid_data_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic                 pop;

   // Collect the visible lanes into one result; absent keys read as zero.
   always_comb begin
      merged = '0;
      for (int i = 0; i < SHOWN_KEYS; i++) begin
         merged.short_press[i] = lane_result[i].short_hit;
         merged.long_press[i]  = lane_result[i].long_hit;
      end
   end

   assign pop      = out_valid_ff && rsp_chan.ready;
   assign can_push = !skid_valid_ff;

   // Output register with a skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = merged;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = merged;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = merged;
         end
      end
   end

   // Valid flags take reset; data registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.short_press = out_data_ff.short_press;
   assign rsp_chan.long_press  = out_data_ff.long_press;

`ifndef SYNTH
   // The skid entry is only used behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // A buffered result is never dropped while the sink stalls.
   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_chan.ready) |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("skid entry lost during a stall");

   // A transfer in with the output full and stalled lands in the skid entry.
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("pushed result not captured in the skid entry");
`endif

endmodule

// ===== design/key_short_long_press_detector.sv =====
// Top level: one lane per key, shared configuration, merged result buffer.
// The pulses of a tick are computed combinationally and registered into the result
// buffer at the edge that transfers the tick in.
// Throughput: one tick per clock while the result buffer has room; the two-entry buffer
// takes one more tick once the result channel stalls, then holds input off until it drains.
// Reset clears every key to idle with a zero count, empties the result buffer and
// loads the thresholds with 78 and 15.
module key_short_long_press_detector #(
   parameter int NUM_KEYS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   kpd_req_if.sink                             req_chan,
   kpd_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [kpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [kpd_pkg::CSR_DATA_W-1:0]  long_threshold_ff, long_threshold_in;
   logic [kpd_pkg::CSR_DATA_W-1:0]  repeat_interval_ff, repeat_interval_in;
   logic                            can_push;
   logic                            advance;
   kpd_pkg::lane_result_type        lane_result [NUM_KEYS];

   // Configuration register writes.
   always_comb begin
      long_threshold_in  = long_threshold_ff;
      repeat_interval_in = repeat_interval_ff;
      if (csr_we) begin
         unique case (kpd_pkg::csr_index_type'(csr_index))
            kpd_pkg::CSR_LONG_THRESHOLD:  long_threshold_in  = csr_wdata;
            kpd_pkg::CSR_REPEAT_INTERVAL: repeat_interval_in = csr_wdata;
            default: begin
               long_threshold_in  = long_threshold_ff;
               repeat_interval_in = repeat_interval_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_threshold_ff  <= kpd_pkg::LONG_THRESHOLD_RESET;
         repeat_interval_ff <= kpd_pkg::REPEAT_INTERVAL_RESET;
      end else begin
         long_threshold_ff  <= long_threshold_in;
         repeat_interval_ff <= repeat_interval_in;
      end
   end

   // A tick advances every lane on the cycle it is transferred in.
   assign req_chan.ready = can_push;
   assign advance        = req_chan.valid && can_push;

   // One press machine per key; keys without an input bit read as pressed.
   for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
      logic pressed;
      if (i < kpd_pkg::KEY_W) begin : g_sampled
         assign pressed = !req_chan.key_levels[i];
      end else begin : g_unsampled
         assign pressed = 1'b1;
      end

      kpd_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .advance         (advance),
         .pressed         (pressed),
         .long_threshold  (long_threshold_ff),
         .repeat_interval (repeat_interval_ff),
         .result          (lane_result[i])
      );
   end

   // Merge the lanes and buffer the result.
   kpd_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (advance),
      .lane_result (lane_result),
      .can_push    (can_push),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== sim/key_short_long_press_detector_tb.sv =====
// Self-checking testbench for the key short/long press detector.
module key_short_long_press_detector_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // Opening ticks: all keys glitch together, then key 0 gives a short press, key 1 lets go
   // on the threshold tick, key 2 holds long enough to repeat, and key 3 first enters
   // long-held and lets go at once, then holds for a single long pulse.
   localparam logic [4*19-1:0] OPENING_TICKS = 76'hF0F_0011_3B33_3377_FFEF;
   localparam int OPENING_LEN = 19;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [kpd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [kpd_pkg::CSR_DATA_W-1:0] csr_wdata;

   kpd_req_if req_bus ();
   kpd_rsp_if rsp_bus ();

   key_short_long_press_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a period of ten time units.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted key state and the copy of the thresholds.
   kpd_pkg::phase_type key_phase [kpd_pkg::KEY_W];
   logic [7:0] hold_ticks [kpd_pkg::KEY_W];
   logic [kpd_pkg::CSR_DATA_W-1:0] long_limit;
   logic [kpd_pkg::CSR_DATA_W-1:0] repeat_every;

   // Ticks waiting to be sent and pulses waiting to be seen.
   logic [kpd_pkg::KEY_W-1:0] ticks_waiting [$];
   kpd_pkg::result_type pulses_due [$];

   // Pattern generator state: whether each key is held and how long the run lasts.
   bit key_down [kpd_pkg::KEY_W];
   int run_left [kpd_pkg::KEY_W];

   int error_count = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int short_total = 0;
   int long_total = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   int burst_left = 0;
   int gap_left = 0;
   bit tick_taken;
   kpd_pkg::result_type tick_pulses;

   rx_mode_type rx_mode = RX_STEADY;
   int rx_mode_left = 0;
   int rx_beat = 0;
   bit rx_next;
   kpd_pkg::result_type pulses_want;

   function automatic logic [7:0] bump_count(input logic [7:0] count);
      return (count == kpd_pkg::HOLD_COUNT_MAX) ? kpd_pkg::HOLD_COUNT_MAX : count + 8'd1;
   endfunction

   // Advance every key by one tick and return the pulses this tick produces.
   function automatic kpd_pkg::result_type next_pulses(
         input logic [kpd_pkg::KEY_W-1:0] levels);
      kpd_pkg::result_type pulses;
      logic pressed;
      pulses = '0;
      for (int k = 0; k < kpd_pkg::KEY_W; k++) begin
         pressed = !levels[k];
         case (key_phase[k])
            kpd_pkg::PH_IDLE: begin
               if (pressed) key_phase[k] = kpd_pkg::PH_FIRST;
            end
            kpd_pkg::PH_FIRST: begin
               key_phase[k] = pressed ? kpd_pkg::PH_HELD : kpd_pkg::PH_IDLE;
            end
            kpd_pkg::PH_HELD: begin
               hold_ticks[k] = bump_count(hold_ticks[k]);
               if (hold_ticks[k] < long_limit && !pressed) begin
                  pulses.short_press[k] = 1'b1;
                  key_phase[k] = kpd_pkg::PH_IDLE;
                  hold_ticks[k] = '0;
               end else if (hold_ticks[k] >= long_limit) begin
                  key_phase[k] = kpd_pkg::PH_LONG;
               end
            end
            default: begin
               if (pressed) begin
                  hold_ticks[k] = bump_count(hold_ticks[k]);
                  if (hold_ticks[k] >= repeat_every) begin
                     pulses.long_press[k] = 1'b1;
                     hold_ticks[k] = '0;
                  end
               end else begin
                  key_phase[k] = kpd_pkg::PH_IDLE;
                  hold_ticks[k] = '0;
               end
            end
         endcase
      end
      return pulses;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Block until nothing is queued, in flight or expected, then let the pipeline drain.
   task automatic settle();
      while (ticks_waiting.size() != 0 || req_bus.valid || pulses_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input kpd_pkg::csr_index_type index,
                            input logic [kpd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == kpd_pkg::CSR_LONG_THRESHOLD) long_limit = value;
      else repeat_every = value;
   endtask

   // Queue ticks built from press and release runs per key, with some noise mixed in.
   task automatic queue_presses(input int count);
      logic [kpd_pkg::KEY_W-1:0] levels;
      int len;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            levels = kpd_pkg::KEY_W'($urandom_range(0, (1 << kpd_pkg::KEY_W) - 1));
         end else begin
            for (int k = 0; k < kpd_pkg::KEY_W; k++) begin
               if (run_left[k] == 0) begin
                  key_down[k] = !key_down[k];
                  if (key_down[k]) begin
                     // Glitches, short presses, releases around the threshold and long holds.
                     case ($urandom_range(0, 9))
                        0: len = 1;
                        1: len = 2;
                        2: len = $urandom_range(3, int'(long_limit) + 2);
                        3, 4: len = int'(long_limit) - 1 + int'($urandom_range(0, 4));
                        default: len = int'(long_limit) + 3
                                       + int'($urandom_range(0, 3 * int'(repeat_every)));
                     endcase
                     if (len < 1) len = 1;
                  end else begin
                     len = $urandom_range(1, 4);
                  end
                  run_left[k] = len;
               end
               levels[k] = !key_down[k];
               run_left[k]--;
            end
         end
         ticks_waiting.push_back(levels);
      end
   endtask

   task automatic run_setting(input logic [7:0] threshold, input logic [7:0] interval,
                              input int count);
      settle();
      write_csr(kpd_pkg::CSR_LONG_THRESHOLD, threshold);
      write_csr(kpd_pkg::CSR_REPEAT_INTERVAL, interval);
      settings_used++;
      queue_presses(count);
   endtask

   // Sender: bursts of ticks with random gaps; one transfer predicts one result.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         tick_taken = req_bus.valid && req_bus.ready;
         if (tick_taken) begin
            tick_pulses = next_pulses(req_bus.key_levels);
            pulses_due.push_back(tick_pulses);
            short_total += $countones(tick_pulses.short_press);
            long_total += $countones(tick_pulses.long_press);
            ticks_sent++;
         end
         if (!req_bus.valid || tick_taken) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (ticks_waiting.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.key_levels <= ticks_waiting.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare each transfer with the oldest prediction and pick the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pulses_due.size() == 0) begin
               flag_error($sformatf("result with nothing expected: short=%h long=%h",
                                    rsp_bus.short_press, rsp_bus.long_press));
            end else begin
               pulses_want = pulses_due.pop_front();
               if (rsp_bus.short_press !== pulses_want.short_press ||
                   rsp_bus.long_press !== pulses_want.long_press)
                  flag_error($sformatf("result %0d: short=%h long=%h, expected short=%h long=%h",
                                       results_seen, rsp_bus.short_press, rsp_bus.long_press,
                                       pulses_want.short_press, pulses_want.long_press));
            end
         end
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 80);
         end else begin
            rx_mode_left--;
         end
         rx_beat = (rx_beat == 6) ? 0 : rx_beat + 1;
         case (rx_mode)
            RX_STEADY:   rx_next = 1'b1;
            RX_RANDOM:   rx_next = ($urandom_range(0, 3) != 0);
            default:     rx_next = (rx_beat > 2);
         endcase
         rsp_bus.ready <= rx_next;
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results still expected",
                  WATCHDOG_LIMIT, pulses_due.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus sequence.
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.key_levels = '1;
      rsp_bus.ready = 1'b0;
      for (int k = 0; k < kpd_pkg::KEY_W; k++) begin
         key_phase[k] = kpd_pkg::PH_IDLE;
         hold_ticks[k] = '0;
         key_down[k] = 1'b0;
         run_left[k] = 0;
      end
      long_limit = kpd_pkg::LONG_THRESHOLD_RESET;
      repeat_every = kpd_pkg::REPEAT_INTERVAL_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening with a short threshold and interval.
      run_setting(8'd3, 8'd2, 0);
      for (int t = OPENING_LEN - 1; t >= 0; t--)
         ticks_waiting.push_back(OPENING_TICKS[4 * t +: 4]);
      queue_presses(30);

      // Reset values, then the extremes, then a few small random settings.
      run_setting(kpd_pkg::LONG_THRESHOLD_RESET, kpd_pkg::REPEAT_INTERVAL_RESET, 70);
      run_setting(8'd1, 8'd1, 40);
      run_setting(8'd254, 8'd255, 262);
      repeat (3) run_setting(8'($urandom_range(1, 12)), 8'($urandom_range(1, 8)), 20);

      settle();
      repeat (4) @(posedge clock);
      $display("Sent %0d ticks and checked %0d results over %0d threshold settings.",
               ticks_sent, results_seen, settings_used);
      $display("Predicted %0d short and %0d long pulses; %0d errors.",
               short_total, long_total, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
